@@ rtl/core/pmb_pkg.sv @@
// Shared types, status codes and a helper function for the priority mailbox.
// Used by the interfaces, the statistics counters and the top level.
package pmb_pkg;

    localparam int unsigned ID_W   = 8;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned LEN_W  = 4;
    localparam int unsigned PRIO_W = 3;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned PEND_W = 5;
    localparam int unsigned GOTP_W = 2;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_PARAM    = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]   src;
        logic [ID_W-1:0]   dst;
        logic [DATA_W-1:0] payload;
        logic [LEN_W-1:0]  len;
    } t_slot;

    typedef struct packed {
        logic sent;
        logic recv;
        logic drop;
    } t_stat_inc;

    typedef struct packed {
        logic [CNT_W-1:0] sent;
        logic [CNT_W-1:0] recv;
        logic [CNT_W-1:0] drop;
    } t_stat_cnt;

    // Bytes at and above the given length are cleared.
    function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] data,
                                                     input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] res;
        res = '0;
        for (int b = 0; b < DATA_W / 8; b++) begin
            if (b < int'(len)) begin
                res[b*8 +: 8] = data[b*8 +: 8];
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/core/pmb_if.sv @@
// Valid/ready channel interfaces for mailbox requests and responses.
// Depends on pmb_pkg for field widths.
interface pmb_req_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [pmb_pkg::ID_W-1:0]      source_module;
    logic [pmb_pkg::ID_W-1:0]      dest_module;
    logic [pmb_pkg::PRIO_W-1:0]    priority_req;
    logic [pmb_pkg::DATA_W-1:0]    data;
    logic [pmb_pkg::LEN_W-1:0]     data_len;

    modport source (output valid, op, source_module, dest_module, priority_req, data,
                    data_len, input ready);
    modport sink   (input valid, op, source_module, dest_module, priority_req, data,
                    data_len, output ready);
endinterface

interface pmb_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pmb_pkg::STAT_W-1:0]    status;
    logic [pmb_pkg::ID_W-1:0]      got_source;
    logic [pmb_pkg::GOTP_W-1:0]    got_priority;
    logic [pmb_pkg::DATA_W-1:0]    got_data;
    logic [pmb_pkg::LEN_W-1:0]     got_len;
    logic [pmb_pkg::CNT_W-1:0]     sent_count;
    logic [pmb_pkg::CNT_W-1:0]     recv_count;
    logic [pmb_pkg::CNT_W-1:0]     dropped_count;
    logic [pmb_pkg::PEND_W-1:0]    pending_count;

    modport source (output valid, status, got_source, got_priority, got_data, got_len,
                    sent_count, recv_count, dropped_count, pending_count, input ready);
    modport sink   (input valid, status, got_source, got_priority, got_data, got_len,
                    sent_count, recv_count, dropped_count, pending_count, output ready);
endinterface

@@ rtl/core/pmb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pmb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned W_ADDR = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [W_ADDR-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [W_ADDR-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/pmb_stats.sv @@
// Saturating sent, received and dropped counters of the mailbox.
// Depends on pmb_pkg for the increment and count structs.
module pmb_stats (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pmb_pkg::t_stat_inc i_inc,
    output pmb_pkg::t_stat_cnt o_cnt_next
);

    localparam logic [pmb_pkg::CNT_W-1:0] SAT = '1;

    pmb_pkg::t_stat_cnt r_cnt;
    pmb_pkg::t_stat_cnt n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_inc.sent && r_cnt.sent != SAT) begin
            n_cnt.sent = r_cnt.sent + 1'b1;
        end
        if (i_inc.recv && r_cnt.recv != SAT) begin
            n_cnt.recv = r_cnt.recv + 1'b1;
        end
        if (i_inc.drop && r_cnt.drop != SAT) begin
            n_cnt.drop = r_cnt.drop + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // The result of an operation reports the counters as they stand after it.
    assign o_cnt_next = n_cnt;

endmodule

@@ rtl/core/priority_mailbox_targeted_dequeue.sv @@
// Priority mailbox with targeted dequeue: one ring per priority in a shared slot RAM.
// A send, or a receive whose target is zero, is answered in the cycle after it.
// Any other receive scans the slots through the RAM read port, then moves the older entries
// of the hit ring up one slot, then finishes; one transaction at a time.
// Reset clears fills, oldest positions and counters; the slot RAM is not cleared.
module priority_mailbox_targeted_dequeue #(
    parameter int unsigned RINGS             = 4,
    parameter int unsigned RING_DEPTH        = 16,
    parameter int unsigned MAX_PAYLOAD_BYTES = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pmb_req_if.sink   i_req,
    pmb_rsp_if.source o_rsp
);

    localparam int unsigned SLOTS  = RINGS * RING_DEPTH;
    localparam int unsigned W_ADDR = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned W_RING = (RINGS > 1) ? $clog2(RINGS) : 1;
    localparam int unsigned W_IDX  = $clog2(RING_DEPTH);
    localparam int unsigned W_POS  = W_IDX + 1;
    localparam int unsigned W_FILL = $clog2(RING_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    function automatic logic [W_ADDR-1:0] slot_addr(input logic [W_IDX-1:0]  oldest,
                                                    input logic [W_RING-1:0] ring,
                                                    input logic [W_IDX-1:0]  k);
        logic [W_POS-1:0] pos;
        pos = {1'b0, oldest} + {1'b0, k};
        if (pos >= W_POS'(RING_DEPTH)) begin
            pos = pos - W_POS'(RING_DEPTH);
        end
        return W_ADDR'(int'(ring) * RING_DEPTH + int'(pos));
    endfunction

    logic [1:0]                    r_state, n_state;
    logic [W_IDX-1:0]              r_oldest [RINGS];
    logic [W_IDX-1:0]              n_oldest [RINGS];
    logic [W_FILL-1:0]             r_fill   [RINGS];
    logic [W_FILL-1:0]             n_fill   [RINGS];
    logic [pmb_pkg::ID_W-1:0]      r_target, n_target;
    logic [pmb_pkg::PRIO_W-1:0]    r_prio, n_prio;

    logic [W_RING-1:0]             r_iss_ring, n_iss_ring;
    logic [W_IDX-1:0]              r_iss_idx, n_iss_idx;
    logic                          r_iss_act, n_iss_act;
    logic                          r_tag_vld, n_tag_vld;
    logic [W_RING-1:0]             r_tag_ring, n_tag_ring;
    logic [W_IDX-1:0]              r_tag_idx, n_tag_idx;

    logic [W_RING-1:0]             r_m_ring, n_m_ring;
    pmb_pkg::t_slot                r_m_slot, n_m_slot;
    logic [pmb_pkg::STAT_W-1:0]    r_fin_st, n_fin_st;
    logic [W_IDX-1:0]              r_sh_rd, n_sh_rd;
    logic [W_IDX-1:0]              r_sh_wr, n_sh_wr;
    logic                          r_sh_more, n_sh_more;
    logic                          r_sh_pend, n_sh_pend;

    logic                          r_ov;
    logic [pmb_pkg::STAT_W-1:0]    r_o_status;
    pmb_pkg::t_slot                r_o_got;
    logic [pmb_pkg::GOTP_W-1:0]    r_o_got_prio;
    pmb_pkg::t_stat_cnt            r_o_cnt;
    logic [pmb_pkg::PEND_W-1:0]    r_o_pend;

    logic                          ram_we;
    logic [W_ADDR-1:0]             ram_waddr, ram_raddr;
    pmb_pkg::t_slot                ram_wdata, ram_rdata;

    pmb_pkg::t_stat_inc            stat_inc;
    pmb_pkg::t_stat_cnt            stat_next;

    logic                          out_free;
    logic                          req_acc;
    logic [W_RING-1:0]             req_ring;
    logic                          req_prio_ok;
    logic                          scan_hit;
    logic [W_FILL-1:0]             iss_fill;
    logic                          out_load;
    logic [pmb_pkg::STAT_W-1:0]    res_status;
    pmb_pkg::t_slot                res_got;
    logic [pmb_pkg::GOTP_W-1:0]    res_got_prio;
    logic [pmb_pkg::PRIO_W-1:0]    pend_prio;
    logic [pmb_pkg::PEND_W-1:0]    pend_cnt;

    pmb_ram #(
        .WIDTH ($bits(pmb_pkg::t_slot)),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pmb_stats u_stats (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_inc      (stat_inc),
        .o_cnt_next (stat_next)
    );

    assign out_free    = !r_ov || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign req_acc     = i_req.valid && i_req.ready;
    assign req_ring    = W_RING'(i_req.priority_req);
    assign req_prio_ok = int'(i_req.priority_req) < RINGS;
    assign scan_hit    = r_tag_vld && (ram_rdata.dst == r_target);
    assign iss_fill    = r_fill[r_iss_ring];

    always_comb begin
        n_state    = r_state;
        n_oldest   = r_oldest;
        n_fill     = r_fill;
        n_target   = r_target;
        n_prio     = r_prio;
        n_iss_ring = r_iss_ring;
        n_iss_idx  = r_iss_idx;
        n_iss_act  = r_iss_act;
        n_tag_vld  = r_tag_vld;
        n_tag_ring = r_tag_ring;
        n_tag_idx  = r_tag_idx;
        n_m_ring   = r_m_ring;
        n_m_slot   = r_m_slot;
        n_fin_st   = r_fin_st;
        n_sh_rd    = r_sh_rd;
        n_sh_wr    = r_sh_wr;
        n_sh_more  = r_sh_more;
        n_sh_pend  = r_sh_pend;

        stat_inc     = '0;
        ram_we       = 1'b0;
        ram_waddr    = slot_addr(r_oldest[r_m_ring], r_m_ring, r_sh_wr);
        ram_wdata    = ram_rdata;
        ram_raddr    = slot_addr(r_oldest[r_iss_ring], r_iss_ring, r_iss_idx);
        out_load     = 1'b0;
        res_status   = pmb_pkg::ST_OK;
        res_got      = '0;
        res_got_prio = '0;
        pend_prio    = r_prio;

        case (r_state)
            S_IDLE: begin
                pend_prio = i_req.priority_req;
                if (req_acc) begin
                    if (i_req.op == pmb_pkg::OP_SEND) begin
                        out_load = 1'b1;
                        if (i_req.source_module == '0 || i_req.dest_module == '0) begin
                            res_status = pmb_pkg::ST_PARAM;
                        end else if (int'(i_req.data_len) > MAX_PAYLOAD_BYTES) begin
                            res_status = pmb_pkg::ST_OVERFLOW;
                        end else if (!req_prio_ok) begin
                            res_status = pmb_pkg::ST_PARAM;
                        end else if (r_fill[req_ring] == W_FILL'(RING_DEPTH)) begin
                            res_status    = pmb_pkg::ST_FULL;
                            stat_inc.drop = 1'b1;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = slot_addr(r_oldest[req_ring], req_ring,
                                                  W_IDX'(r_fill[req_ring]));
                            ram_wdata.src     = i_req.source_module;
                            ram_wdata.dst     = i_req.dest_module;
                            ram_wdata.payload = pmb_pkg::keep_bytes(i_req.data,
                                                                    i_req.data_len);
                            ram_wdata.len     = i_req.data_len;
                            n_fill[req_ring]  = r_fill[req_ring] + 1'b1;
                            stat_inc.sent     = 1'b1;
                        end
                    end else if (i_req.dest_module == '0) begin
                        out_load   = 1'b1;
                        res_status = pmb_pkg::ST_PARAM;
                    end else begin
                        n_state    = S_SCAN;
                        n_target   = i_req.dest_module;
                        n_prio     = i_req.priority_req;
                        n_iss_ring = W_RING'(RINGS - 1);
                        n_iss_idx  = '0;
                        n_iss_act  = 1'b1;
                        n_tag_vld  = 1'b0;
                    end
                end
            end
            S_SCAN: begin
                // One slot read is issued per cycle; the compare sees the previous read.
                if (scan_hit) begin
                    n_m_ring  = r_tag_ring;
                    n_m_slot  = ram_rdata;
                    n_fin_st  = pmb_pkg::ST_OK;
                    n_tag_vld = 1'b0;
                    if (r_tag_idx == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state   = S_SHIFT;
                        n_sh_rd   = r_tag_idx - 1'b1;
                        n_sh_more = 1'b1;
                        n_sh_pend = 1'b0;
                    end
                end else if (r_iss_act) begin
                    n_tag_vld  = W_FILL'(r_iss_idx) < iss_fill;
                    n_tag_ring = r_iss_ring;
                    n_tag_idx  = r_iss_idx;
                    if (W_FILL'(r_iss_idx) + 1'b1 >= iss_fill) begin
                        n_iss_idx = '0;
                        if (r_iss_ring == '0) begin
                            n_iss_act = 1'b0;
                        end else begin
                            n_iss_ring = r_iss_ring - 1'b1;
                        end
                    end else begin
                        n_iss_idx = r_iss_idx + 1'b1;
                    end
                end else if (!r_tag_vld) begin
                    n_state  = S_FIN;
                    n_fin_st = pmb_pkg::ST_EMPTY;
                end else begin
                    n_tag_vld = 1'b0;
                end
            end
            S_SHIFT: begin
                // Each older entry moves up one slot: read it, write it one place later.
                ram_raddr = slot_addr(r_oldest[r_m_ring], r_m_ring, r_sh_rd);
                ram_we    = r_sh_pend;
                if (r_sh_more) begin
                    n_sh_wr   = r_sh_rd + 1'b1;
                    n_sh_pend = 1'b1;
                    if (r_sh_rd == '0) begin
                        n_sh_more = 1'b0;
                    end else begin
                        n_sh_rd = r_sh_rd - 1'b1;
                    end
                end else begin
                    n_sh_pend = 1'b0;
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    res_status = r_fin_st;
                    n_state    = S_IDLE;
                    if (r_fin_st == pmb_pkg::ST_OK) begin
                        res_got      = r_m_slot;
                        res_got_prio = pmb_pkg::GOTP_W'(r_m_ring);
                        n_fill[r_m_ring] = r_fill[r_m_ring] - 1'b1;
                        if (r_oldest[r_m_ring] == W_IDX'(RING_DEPTH - 1)) begin
                            n_oldest[r_m_ring] = '0;
                        end else begin
                            n_oldest[r_m_ring] = r_oldest[r_m_ring] + 1'b1;
                        end
                        stat_inc.recv = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (int'(pend_prio) < RINGS) begin
            pend_cnt = pmb_pkg::PEND_W'(n_fill[W_RING'(pend_prio)]);
        end else begin
            pend_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_iss_act <= 1'b0;
            r_tag_vld <= 1'b0;
            r_sh_more <= 1'b0;
            r_sh_pend <= 1'b0;
            r_ov      <= 1'b0;
            for (int r = 0; r < RINGS; r++) begin
                r_oldest[r] <= '0;
                r_fill[r]   <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_iss_act <= n_iss_act;
            r_tag_vld <= n_tag_vld;
            r_sh_more <= n_sh_more;
            r_sh_pend <= n_sh_pend;
            r_oldest  <= n_oldest;
            r_fill    <= n_fill;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_target   <= n_target;
        r_prio     <= n_prio;
        r_iss_ring <= n_iss_ring;
        r_iss_idx  <= n_iss_idx;
        r_tag_ring <= n_tag_ring;
        r_tag_idx  <= n_tag_idx;
        r_m_ring   <= n_m_ring;
        r_m_slot   <= n_m_slot;
        r_fin_st   <= n_fin_st;
        r_sh_rd    <= n_sh_rd;
        r_sh_wr    <= n_sh_wr;
        if (out_load) begin
            r_o_status   <= res_status;
            r_o_got      <= res_got;
            r_o_got_prio <= res_got_prio;
            r_o_cnt      <= stat_next;
            r_o_pend     <= pend_cnt;
        end
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.got_source    = r_o_got.src;
    assign o_rsp.got_priority  = r_o_got_prio;
    assign o_rsp.got_data      = r_o_got.payload;
    assign o_rsp.got_len       = r_o_got.len;
    assign o_rsp.sent_count    = r_o_cnt.sent;
    assign o_rsp.recv_count    = r_o_cnt.recv;
    assign o_rsp.dropped_count = r_o_cnt.drop;
    assign o_rsp.pending_count = r_o_pend;

    // A hit is only ever taken from a slot that lies inside the ring's fill.
    a_hit_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && scan_hit) |-> (W_FILL'(r_tag_idx) < r_fill[r_tag_ring]))
        else $error("scan hit outside ring fill");

    // Once the last read of the shift is issued, its write must still be pending.
    a_shift_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && !r_sh_more) |-> r_sh_pend)
        else $error("shift finished without its last write");

    // A send is answered in the cycle after its transaction.
    a_send_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.op == pmb_pkg::OP_SEND) |=> o_rsp.valid)
        else $error("send without a response");

    // No new request is taken while a receive is in progress.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready)
        else $error("request accepted while busy");

    // The slot RAM is never written while the scan is reading it.
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !ram_we)
        else $error("slot write during scan");

endmodule

@@ bench/tb_priority_mailbox_targeted_dequeue.sv @@
// Self-checking bench for priority_mailbox_targeted_dequeue: queued requests through a bursty
// driver, replies checked by a stalling monitor against a per-ring queue model of the mailbox.
// Depends on pmb_pkg and the pmb_req_if / pmb_rsp_if channel interfaces.
`timescale 1ns / 1ps

module tb_priority_mailbox_targeted_dequeue;

    localparam int unsigned RINGS             = 4;
    localparam int unsigned RING_DEPTH        = 16;
    localparam int unsigned MAX_PAYLOAD_BYTES = 8;
    localparam int          RANDOM_ITEMS      = 750;
    localparam int          DRAIN_CYCLES      = 2 * RINGS * RING_DEPTH + 16;

    typedef struct packed {
        logic                       op;
        logic [pmb_pkg::ID_W-1:0]   src;
        logic [pmb_pkg::ID_W-1:0]   dst;
        logic [pmb_pkg::PRIO_W-1:0] prio;
        logic [pmb_pkg::DATA_W-1:0] data;
        logic [pmb_pkg::LEN_W-1:0]  len;
    } t_mbox_req;

    typedef struct packed {
        logic [pmb_pkg::STAT_W-1:0] status;
        logic [pmb_pkg::ID_W-1:0]   got_source;
        logic [pmb_pkg::GOTP_W-1:0] got_priority;
        logic [pmb_pkg::DATA_W-1:0] got_data;
        logic [pmb_pkg::LEN_W-1:0]  got_len;
        logic [pmb_pkg::CNT_W-1:0]  sent;
        logic [pmb_pkg::CNT_W-1:0]  recv;
        logic [pmb_pkg::CNT_W-1:0]  dropped;
        logic [pmb_pkg::PEND_W-1:0] pending;
    } t_mbox_rsp;

    logic i_clk;
    logic i_rst_n;

    pmb_req_if req_ch ();
    pmb_rsp_if rsp_ch ();

    priority_mailbox_targeted_dequeue #(
        .RINGS             (RINGS),
        .RING_DEPTH        (RING_DEPTH),
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Mailbox model: each ring is kept oldest first, so a targeted take is a plain delete.
    pmb_pkg::t_slot            ring_msgs [RINGS][$];
    logic [pmb_pkg::CNT_W-1:0] sent_total    = '0;
    logic [pmb_pkg::CNT_W-1:0] recv_total    = '0;
    logic [pmb_pkg::CNT_W-1:0] dropped_total = '0;

    t_mbox_req request_backlog[$];
    t_mbox_rsp expected_replies[$];
    t_mbox_req in_flight;
    int        item_total     = 0;
    int        accepted_total = 0;
    int        error_count    = 0;
    int        burst_left     = 0;
    int        gap_left       = 0;
    int        stall_cycle    = 0;
    int        stall_mode     = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [pmb_pkg::CNT_W-1:0] sat_inc(input logic [pmb_pkg::CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [pmb_pkg::DATA_W-1:0] payload_mask(
        input logic [pmb_pkg::LEN_W-1:0] len);
        logic [pmb_pkg::DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < pmb_pkg::DATA_W / 8; b++) begin
            if (b < int'(len)) m[b*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction

    // Applies one transaction to the mailbox model and returns the reply it should produce.
    function automatic t_mbox_rsp apply_to_rings(input t_mbox_req rq);
        t_mbox_rsp      rs;
        pmb_pkg::t_slot entry;
        bit             found;
        rs    = '0;
        found = 1'b0;
        if (rq.op == pmb_pkg::OP_SEND) begin
            if (rq.src == '0 || rq.dst == '0) begin
                rs.status = pmb_pkg::ST_PARAM;
            end else if (rq.len > MAX_PAYLOAD_BYTES) begin
                rs.status = pmb_pkg::ST_OVERFLOW;
            end else if (rq.prio >= RINGS) begin
                rs.status = pmb_pkg::ST_PARAM;
            end else if (ring_msgs[rq.prio].size() >= RING_DEPTH) begin
                rs.status     = pmb_pkg::ST_FULL;
                dropped_total = sat_inc(dropped_total);
            end else begin
                entry.src     = rq.src;
                entry.dst     = rq.dst;
                entry.payload = rq.data & payload_mask(rq.len);
                entry.len     = rq.len;
                ring_msgs[rq.prio].push_back(entry);
                sent_total = sat_inc(sent_total);
                rs.status  = pmb_pkg::ST_OK;
            end
        end else if (rq.dst == '0) begin
            rs.status = pmb_pkg::ST_PARAM;
        end else begin
            rs.status = pmb_pkg::ST_EMPTY;
            for (int r = RINGS - 1; r >= 0 && !found; r--) begin
                for (int k = 0; k < ring_msgs[r].size() && !found; k++) begin
                    if (ring_msgs[r][k].dst == rq.dst) begin
                        found           = 1'b1;
                        rs.status       = pmb_pkg::ST_OK;
                        rs.got_source   = ring_msgs[r][k].src;
                        rs.got_priority = pmb_pkg::GOTP_W'(r);
                        rs.got_data     = ring_msgs[r][k].payload;
                        rs.got_len      = ring_msgs[r][k].len;
                        ring_msgs[r].delete(k);
                        recv_total = sat_inc(recv_total);
                    end
                end
            end
        end
        rs.sent    = sent_total;
        rs.recv    = recv_total;
        rs.dropped = dropped_total;
        rs.pending = (rq.prio < RINGS) ? pmb_pkg::PEND_W'(ring_msgs[rq.prio].size()) : '0;
        return rs;
    endfunction

    function automatic t_mbox_req make_req(input logic op,
                                           input logic [pmb_pkg::ID_W-1:0] src,
                                           input logic [pmb_pkg::ID_W-1:0] dst,
                                           input logic [pmb_pkg::PRIO_W-1:0] prio,
                                           input logic [pmb_pkg::DATA_W-1:0] data,
                                           input logic [pmb_pkg::LEN_W-1:0] len);
        t_mbox_req rq;
        rq.op   = op;
        rq.src  = src;
        rq.dst  = dst;
        rq.prio = prio;
        rq.data = data;
        rq.len  = len;
        return rq;
    endfunction

    // A small pool of destination ids keeps receives finding messages and rings filling up.
    function automatic t_mbox_req make_random_request(input int send_pct);
        t_mbox_req rq;
        int        roll;
        rq.op   = ($urandom_range(0, 99) < send_pct) ? pmb_pkg::OP_SEND : pmb_pkg::OP_RECV;
        rq.data = {$urandom, $urandom};
        roll    = $urandom_range(0, 99);
        rq.src  = (roll < 5) ? 8'd0 : (roll < 10) ? 8'd255
                                                   : pmb_pkg::ID_W'($urandom_range(1, 254));
        roll    = $urandom_range(0, 99);
        if (roll < 4)       rq.dst = '0;
        else if (roll < 12) rq.dst = pmb_pkg::ID_W'($urandom_range(1, 255));
        else                rq.dst = pmb_pkg::ID_W'($urandom_range(1, 4));
        rq.prio = ($urandom_range(0, 99) < 8) ? pmb_pkg::PRIO_W'($urandom_range(4, 7))
                                               : pmb_pkg::PRIO_W'($urandom_range(0, 3));
        rq.len  = ($urandom_range(0, 99) < 8) ? pmb_pkg::LEN_W'($urandom_range(9, 15))
                                               : pmb_pkg::LEN_W'($urandom_range(0, 8));
        return rq;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Driver: holds a transaction until it is taken, then works through the backlog in bursts.
    always @(posedge i_clk) begin
        logic drive;
        drive = 1'b0;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_replies.push_back(apply_to_rings(in_flight));
                accepted_total++;
            end
            if (req_ch.valid && !req_ch.ready) begin
                drive = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (request_backlog.size() > 0) begin
                in_flight = request_backlog.pop_front();
                drive     = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 11);
                    gap_left   = $urandom_range(0, 6);
                end
            end
            req_ch.valid <= drive;
            if (drive) begin
                req_ch.op            <= in_flight.op;
                req_ch.source_module <= in_flight.src;
                req_ch.dest_module   <= in_flight.dst;
                req_ch.priority_req  <= in_flight.prio;
                req_ch.data          <= in_flight.data;
                req_ch.data_len      <= in_flight.len;
            end
        end
    end

    // Monitor: checks each reply against the oldest expectation and stalls in changing patterns.
    always @(posedge i_clk) begin
        t_mbox_rsp want;
        logic      take;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_replies.size() == 0) begin
                $error("reply with no transaction outstanding, status %0d", rsp_ch.status);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                compare_field("status", want.status, rsp_ch.status);
                compare_field("got_source", want.got_source, rsp_ch.got_source);
                compare_field("got_priority", want.got_priority, rsp_ch.got_priority);
                compare_field("got_data", want.got_data, rsp_ch.got_data);
                compare_field("got_len", want.got_len, rsp_ch.got_len);
                compare_field("sent_count", want.sent, rsp_ch.sent_count);
                compare_field("recv_count", want.recv, rsp_ch.recv_count);
                compare_field("dropped_count", want.dropped, rsp_ch.dropped_count);
                compare_field("pending_count", want.pending, rsp_ch.pending_count);
            end
        end
        stall_cycle++;
        if (stall_cycle % 97 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: take = 1'b1;
            1: take = (stall_cycle % 3) != 0;
            2: take = 1'($urandom_range(0, 1));
            default: take = (stall_cycle % 4) == 0;
        endcase
        rsp_ch.ready <= i_rst_n ? take : 1'b0;
    end

    initial begin
        t_mbox_req rq;
        int        send_pct;
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.op            = pmb_pkg::OP_SEND;
        req_ch.source_module = '0;
        req_ch.dest_module   = '0;
        req_ch.priority_req  = '0;
        req_ch.data          = '0;
        req_ch.data_len      = '0;
        rsp_ch.ready         = 1'b0;
        send_pct             = 70;

        // Fill the top ring to the brim, with one message for target 2 part-way in.
        for (int k = 0; k < RING_DEPTH; k++) begin
            rq = make_req(pmb_pkg::OP_SEND, (k == 0) ? 8'd255 : pmb_pkg::ID_W'(k + 1),
                          (k == 5) ? 8'd2 : (k == RING_DEPTH - 1) ? 8'd255 : 8'd1,
                          3'd3, (k < 2) ? '1 : {$urandom, $urandom},
                          (k == 0) ? 4'd8 : (k == 1) ? 4'd0 : pmb_pkg::LEN_W'(k % 9));
            request_backlog.push_back(rq);
        end
        // The ring is now full, so this send is dropped.
        request_backlog.push_back(make_req(pmb_pkg::OP_SEND, 8'd9, 8'd1, 3'd3, '1, 4'd4));
        // Take the message from the middle of the ring; older entries close the gap.
        request_backlog.push_back(make_req(pmb_pkg::OP_RECV, 8'd0, 8'd2, 3'd3, '0, 4'd0));
        request_backlog.push_back(make_req(pmb_pkg::OP_RECV, 8'd5, 8'd0, 3'd7, '1, 4'd15));
        request_backlog.push_back(make_req(pmb_pkg::OP_RECV, 8'd5, 8'd77, 3'd2, '0, 4'd0));
        request_backlog.push_back(make_req(pmb_pkg::OP_SEND, 8'd0, 8'd3, 3'd0, '1, 4'd15));
        request_backlog.push_back(make_req(pmb_pkg::OP_SEND, 8'd4, 8'd0, 3'd1, '1, 4'd3));
        request_backlog.push_back(make_req(pmb_pkg::OP_SEND, 8'd4, 8'd3, 3'd1, '1, 4'd9));
        // Length is checked before priority.
        request_backlog.push_back(make_req(pmb_pkg::OP_SEND, 8'd4, 8'd3, 3'd5, '1, 4'd15));
        request_backlog.push_back(make_req(pmb_pkg::OP_SEND, 8'd4, 8'd3, 3'd7, '1, 4'd2));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: send_pct = 85;
                    1: send_pct = 35;
                    default: send_pct = 60;
                endcase
            end
            request_backlog.push_back(make_random_request(send_pct));
        end
        item_total = request_backlog.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (accepted_total == item_total && expected_replies.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/pmb_pkg.sv
rtl/core/pmb_if.sv
rtl/core/pmb_ram.sv
rtl/core/pmb_stats.sv
rtl/core/priority_mailbox_targeted_dequeue.sv
bench/tb_priority_mailbox_targeted_dequeue.sv
